### design/sdiv_pkg.sv
`default_nettype none

package sdiv_pkg;

  localparam int unsigned Width = 16;

  typedef struct packed {
    logic valid;
    logic neg;
  } sdiv_ctrl_t;

endpackage

`default_nettype wire

### design/signed_restoring_divider_unit.sv
// Channel   | Handshake         | Ports
// ----------+-------------------+------------------------------------------
// request   | start_i, busy_o   | dividend_i, divisor_i
// result    | done_o (strobe)   | quotient_o, remainder_o
//
// A request is taken in every cycle; busy_o stays low.
// One pipeline stage forms the magnitudes, one stage per quotient bit runs
// a restoring step, and one stage applies the sign.
// Reset clears the valid bits of every stage; requests in flight are lost.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module signed_restoring_divider_unit #(
  parameter int unsigned WIDTH = sdiv_pkg::Width
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  output logic                     busy_o,
  input  wire  signed [WIDTH-1:0]  dividend_i,
  input  wire  signed [WIDTH-1:0]  divisor_i,
  output logic                     done_o,
  output logic signed [WIDTH-1:0]  quotient_o,
  output logic        [WIDTH-1:0]  remainder_o
);

  sdiv_pkg::sdiv_ctrl_t ctrl_s [WIDTH+1];
  logic [WIDTH-1:0]     acc_s  [WIDTH+1];
  logic [WIDTH-1:0]     q_s    [WIDTH+1];
  logic [WIDTH-1:0]     d_s    [WIDTH+1];

  assign busy_o   = 1'b0;
  assign acc_s[0] = '0;

  sdiv_prep #(
    .WIDTH(WIDTH)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i),
    .dividend_i(dividend_i),
    .divisor_i (divisor_i),
    .ctrl_o    (ctrl_s[0]),
    .q_o       (q_s[0]),
    .d_o       (d_s[0])
  );

  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    sdiv_step #(
      .WIDTH(WIDTH)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl_s[i]),
      .acc_i (acc_s[i]),
      .q_i   (q_s[i]),
      .d_i   (d_s[i]),
      .ctrl_o(ctrl_s[i+1]),
      .acc_o (acc_s[i+1]),
      .q_o   (q_s[i+1]),
      .d_o   (d_s[i+1])
    );
  end

  sdiv_post #(
    .WIDTH(WIDTH)
  ) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl_s[WIDTH]),
    .q_i        (q_s[WIDTH]),
    .acc_i      (acc_s[WIDTH]),
    .done_o     (done_o),
    .quotient_o (quotient_o),
    .remainder_o(remainder_o)
  );

  a_request_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(WIDTH+2) done_o)
    else $error("A request did not produce its result on time.");

  a_done_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, WIDTH+2))
    else $error("A result appeared without a matching request.");

  a_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_s[WIDTH].valid && (d_s[WIDTH] == '0)) |-> (q_s[WIDTH] == '1))
    else $error("A zero divisor did not give an all-ones quotient magnitude.");

endmodule

`default_nettype wire

### design/sdiv_prep.sv
`default_nettype none

module sdiv_prep #(
  parameter int unsigned WIDTH = sdiv_pkg::Width
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      valid_i,
  input  wire  signed [WIDTH-1:0]  dividend_i,
  input  wire  signed [WIDTH-1:0]  divisor_i,
  output sdiv_pkg::sdiv_ctrl_t     ctrl_o,
  output logic        [WIDTH-1:0]  q_o,
  output logic        [WIDTH-1:0]  d_o
);

  localparam logic [WIDTH-1:0] One = {{(WIDTH-1){1'b0}}, 1'b1};

  logic [WIDTH-1:0]     a_raw, b_raw;
  logic [WIDTH-1:0]     q_d, q_q, d_d, d_q;
  sdiv_pkg::sdiv_ctrl_t ctrl_d, ctrl_q;

  always_comb begin
    a_raw        = $unsigned(dividend_i);
    b_raw        = $unsigned(divisor_i);
    q_d          = a_raw[WIDTH-1] ? ((~a_raw) + One) : a_raw;
    d_d          = b_raw[WIDTH-1] ? ((~b_raw) + One) : b_raw;
    ctrl_d.valid = valid_i;
    ctrl_d.neg   = a_raw[WIDTH-1] ^ b_raw[WIDTH-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    d_q <= d_d;
  end

  assign ctrl_o = ctrl_q;
  assign q_o    = q_q;
  assign d_o    = d_q;

endmodule

`default_nettype wire

### design/sdiv_step.sv
`default_nettype none

module sdiv_step #(
  parameter int unsigned WIDTH = sdiv_pkg::Width
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire sdiv_pkg::sdiv_ctrl_t  ctrl_i,
  input  wire   [WIDTH-1:0]          acc_i,
  input  wire   [WIDTH-1:0]          q_i,
  input  wire   [WIDTH-1:0]          d_i,
  output sdiv_pkg::sdiv_ctrl_t       ctrl_o,
  output logic  [WIDTH-1:0]          acc_o,
  output logic  [WIDTH-1:0]          q_o,
  output logic  [WIDTH-1:0]          d_o
);

  logic [WIDTH-1:0]     shifted;
  logic [WIDTH:0]       diff;
  logic                 take;
  logic [WIDTH-1:0]     acc_d, acc_q, q_d, q_q, d_q;
  sdiv_pkg::sdiv_ctrl_t ctrl_q;

  always_comb begin
    shifted = {acc_i[WIDTH-2:0], q_i[WIDTH-1]};
    diff    = {acc_i[WIDTH-1], shifted} - {1'b0, d_i};
    take    = ~diff[WIDTH];
    acc_d   = take ? diff[WIDTH-1:0] : shifted;
    q_d     = {q_i[WIDTH-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    q_q   <= q_d;
    d_q   <= d_i;
  end

  assign ctrl_o = ctrl_q;
  assign acc_o  = acc_q;
  assign q_o    = q_q;
  assign d_o    = d_q;

endmodule

`default_nettype wire

### design/sdiv_post.sv
`default_nettype none

module sdiv_post #(
  parameter int unsigned WIDTH = sdiv_pkg::Width
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire sdiv_pkg::sdiv_ctrl_t   ctrl_i,
  input  wire         [WIDTH-1:0]     q_i,
  input  wire         [WIDTH-1:0]     acc_i,
  output logic                        done_o,
  output logic signed [WIDTH-1:0]     quotient_o,
  output logic        [WIDTH-1:0]     remainder_o
);

  localparam logic [WIDTH-1:0] One = {{(WIDTH-1){1'b0}}, 1'b1};

  logic [WIDTH-1:0] quot_d, quot_q, rem_q;
  logic             done_q;

  assign quot_d = ctrl_i.neg ? ((~q_i) + One) : q_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= acc_i;
  end

  assign done_o      = done_q;
  assign quotient_o  = $signed(quot_q);
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

### test/tb_signed_restoring_divider_unit.sv
`timescale 1ns / 100ps

module tb_signed_restoring_divider_unit;

  localparam int unsigned W = sdiv_pkg::Width;
  localparam int unsigned NumRandomRequests = 600;
  localparam int unsigned Latency = W + 2;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
  } division_result_t;

  class division_scoreboard;
    division_result_t pending_quotients[$];
    int unsigned      mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Restoring division on magnitudes, with the sign applied to the quotient only.
    function automatic division_result_t divide_signed(word_t num, word_t den);
      logic [W:0]       acc;
      word_t            mag_num;
      word_t            mag_den;
      word_t            quo;
      division_result_t res;
      mag_num = num[W-1] ? word_t'(-num) : num;
      mag_den = den[W-1] ? word_t'(-den) : den;
      acc = '0;
      quo = mag_num;
      for (int i = 0; i < W; i++) begin
        acc = {acc[W-1:0], quo[W-1]};
        quo = quo << 1;
        if (acc >= {1'b0, mag_den}) begin
          acc = acc - {1'b0, mag_den};
          quo[0] = 1'b1;
        end
      end
      res.quotient  = (num[W-1] ^ den[W-1]) ? word_t'(-quo) : quo;
      res.remainder = acc[W-1:0];
      return res;
    endfunction

    function void note_request(word_t num, word_t den);
      pending_quotients.push_back(divide_signed(num, den));
    endfunction

    function void check_result(word_t quo, word_t rem);
      division_result_t exp;
      if (pending_quotients.size() == 0) begin
        $display("%0t: unexpected result quotient=%h remainder=%h", $time, quo, rem);
        mismatch_count++;
        return;
      end
      exp = pending_quotients.pop_front();
      if (quo !== exp.quotient) begin
        $display("%0t: quotient expected %h actual %h", $time, exp.quotient, quo);
        mismatch_count++;
      end
      if (rem !== exp.remainder) begin
        $display("%0t: remainder expected %h actual %h", $time, exp.remainder, rem);
        mismatch_count++;
      end
    endfunction

    function int unsigned pending_count();
      return pending_quotients.size();
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  logic  busy_o;
  word_t dividend_i;
  word_t divisor_i;
  logic  done_o;
  word_t quotient_o;
  word_t remainder_o;

  division_scoreboard sb = new();

  signed_restoring_divider_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .done_o     (done_o),
    .quotient_o (quotient_o),
    .remainder_o(remainder_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        sb.note_request(dividend_i, divisor_i);
      end
      if (done_o) begin
        sb.check_result(quotient_o, remainder_o);
      end
    end
  end

  task automatic send_division(input word_t num, input word_t den);
    @(negedge clk_i);
    start_i    = 1'b1;
    dividend_i = num;
    divisor_i  = den;
    do begin
      @(posedge clk_i);
    end while (busy_o);
  endtask

  task automatic idle_cycles(input int unsigned n);
    @(negedge clk_i);
    start_i    = 1'b0;
    dividend_i = word_t'($urandom);
    divisor_i  = word_t'($urandom);
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk_i);
  endtask

  function automatic word_t pick_operand();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return {1'b1, {(W-1){1'b0}}};
          1:       return {1'b0, {(W-1){1'b1}}};
          2:       return '0;
          3:       return '1;
          default: return word_t'(1);
        endcase
      end
      1, 2:    return word_t'(int'($urandom_range(0, 32)) - 16);
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    word_t       min_val;
    word_t       max_val;
    int unsigned sent;
    int unsigned burst;
    min_val    = {1'b1, {(W-1){1'b0}}};
    max_val    = {1'b0, {(W-1){1'b1}}};
    start_i    = 1'b0;
    dividend_i = '0;
    divisor_i  = '0;
    rst_ni     = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    send_division('0, word_t'(1));
    send_division('0, '0);
    send_division(word_t'(12345), '0);
    send_division(word_t'(-12345), '0);
    send_division(min_val, '0);
    send_division(max_val, '0);
    send_division(min_val, '1);
    send_division(min_val, word_t'(1));
    send_division(max_val, '1);
    send_division(min_val, min_val);
    send_division(max_val, max_val);
    send_division(min_val, max_val);
    send_division(max_val, min_val);
    send_division(word_t'(1), min_val);
    send_division('0, min_val);
    send_division('1, '1);
    send_division(word_t'(7), word_t'(2));
    send_division(word_t'(-7), word_t'(2));
    send_division(word_t'(7), word_t'(-2));
    send_division(word_t'(-7), word_t'(-2));
    send_division(word_t'(3), word_t'(100));
    send_division(word_t'(-3), word_t'(-100));
    wait_for_drain();

    sent = 0;
    while (sent < NumRandomRequests) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < NumRandomRequests; i++) begin
        send_division(pick_operand(), pick_operand());
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        wait_for_drain();
      end else if ($urandom_range(0, 2) != 0) begin
        idle_cycles($urandom_range(1, 2 * Latency));
      end
    end

    wait_for_drain();
    repeat (Latency + 4) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
design/sdiv_pkg.sv
design/sdiv_prep.sv
design/sdiv_step.sv
design/sdiv_post.sv
design/signed_restoring_divider_unit.sv
test/tb_signed_restoring_divider_unit.sv
